[rtl/cvmcc_pkg.sv]
// shared types, constants and helpers of the cv to midi cc scanner
package cvmcc_pkg;

    // block dimensions
    localparam int NUM_CHANNELS    = 16;
    localparam int NUM_CONTROLLERS = 128;
    localparam int PHASE_BITS      = 24;

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CC_W   = $clog2(NUM_CONTROLLERS);
    localparam int MV_W   = 15;
    localparam int KIND_W = 1;
    localparam int CHF_W  = 4;
    localparam int MIDI_W = 4;
    localparam int VAL_W  = 7;
    localparam int STEP_W = 24;
    localparam int MAP_W  = 56;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CC_MAP_LOW   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CC_MAP_HIGH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHANNEL = 8'd3;

    localparam logic [STEP_W-1:0] PHASE_STEP_RST  = 24'd34953;
    localparam logic [MAP_W-1:0]  CC_MAP_LOW_RST  = 56'd3967210831773824;
    localparam logic [MAP_W-1:0]  CC_MAP_HIGH_RST = 56'd8506271873533064;
    localparam logic [MIDI_W-1:0] MIDI_CHAN_RST   = 4'd0;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // quantizer: round(mv * 127 / 10000) via reciprocal multiply
    localparam int X_W     = 21;
    localparam int RECIP_W = 24;
    localparam int PROD_W  = X_W + RECIP_W;
    localparam int Q_SHIFT = 37;
    localparam int Q_W     = PROD_W - Q_SHIFT;
    localparam logic [X_W-1:0]     Q_HALF  = 21'd5000;
    localparam logic [RECIP_W-1:0] Q_RECIP = 24'd13743896;
    localparam logic [VAL_W-1:0]   CC_MAX  = 7'd127;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [STEP_W-1:0] phase_step;
        logic [MAP_W-1:0]  cc_map_low;
        logic [MAP_W-1:0]  cc_map_high;
        logic [MIDI_W-1:0] midi_channel;
    } t_cfg;

    // requests from the front end to the scan engine
    typedef struct packed {
        logic                   start;
        logic                   smp_we;
        logic [CH_W-1:0]        smp_ch;
        logic signed [MV_W-1:0] smp_mv;
    } t_scan_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MULT,
        ST_CMP,
        ST_FLUSH
    } t_scan_state;

    // controller number that the channel map gives one channel
    function automatic logic [CC_W-1:0] cc_of(input t_cfg cfg, input logic [CHF_W-1:0] ch);
        logic [2*MAP_W-1:0] map;
        map = {cfg.cc_map_high, cfg.cc_map_low};
        return map[VAL_W*ch +: CC_W];
    endfunction

endpackage

[rtl/cvmcc_if.sv]
// valid/ready channel interfaces of the cv to midi cc scanner
interface cvmcc_in_if;
    import cvmcc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [CHF_W-1:0]       channel;
    logic signed [MV_W-1:0] voltage_mv;

    modport source(output valid, kind, channel, voltage_mv, input ready);
    modport sink(input valid, kind, channel, voltage_mv, output ready);
endinterface

interface cvmcc_out_if;
    import cvmcc_pkg::*;
    logic              valid;
    logic              ready;
    logic [MIDI_W-1:0] midi_chan;
    logic [CC_W-1:0]   controller;
    logic [VAL_W-1:0]  cc_value;
    logic              last;

    modport source(output valid, midi_chan, controller, cc_value, last, input ready);
    modport sink(input valid, midi_chan, controller, cc_value, last, output ready);
endinterface

interface cvmcc_cfg_if;
    import cvmcc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[rtl/cvmcc_cfg_regs.sv]
// configuration register file
module cvmcc_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cvmcc_cfg_if.sink        i_cfg,
    output cvmcc_pkg::t_cfg  o_cfg
);
    import cvmcc_pkg::*;

    t_cfg r_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register write, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step   <= PHASE_STEP_RST;
            r_cfg.cc_map_low   <= CC_MAP_LOW_RST;
            r_cfg.cc_map_high  <= CC_MAP_HIGH_RST;
            r_cfg.midi_channel <= MIDI_CHAN_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PHASE_STEP:   r_cfg.phase_step   <= i_cfg.data[STEP_W-1:0];
                REG_CC_MAP_LOW:   r_cfg.cc_map_low   <= i_cfg.data[MAP_W-1:0];
                REG_CC_MAP_HIGH:  r_cfg.cc_map_high  <= i_cfg.data[MAP_W-1:0];
                REG_MIDI_CHANNEL: r_cfg.midi_channel <= i_cfg.data[MIDI_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/cvmcc_quantizer.sv]
// millivolts to 7-bit cc value, one registered multiply stage
module cvmcc_quantizer (
    input  logic                              i_clk,
    input  logic signed [cvmcc_pkg::MV_W-1:0] i_mv,
    output logic [cvmcc_pkg::VAL_W-1:0]       o_value
);
    import cvmcc_pkg::*;

    logic [X_W-1:0]    x;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] r_prod;
    logic [Q_W-1:0]    q;
    logic              pos;

    // mv * 127 + 5000 as shift and subtract, then times 2^37 / 10000
    assign pos  = (i_mv > 0);
    assign x    = (X_W'(i_mv[MV_W-2:0]) << 7) - X_W'(i_mv[MV_W-2:0]) + Q_HALF;
    assign prod = PROD_W'(x) * PROD_W'(Q_RECIP);

    always_ff @(posedge i_clk) begin
        r_prod <= pos ? prod : '0;
    end

    // floor of the scaled product, saturated at full scale
    assign q       = r_prod[Q_SHIFT +: Q_W];
    assign o_value = (q > Q_W'(CC_MAX)) ? CC_MAX : q[VAL_W-1:0];

endmodule

[rtl/cvmcc_engine.sv]
// scan sequencer with sample memory and last-sent table
module cvmcc_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cvmcc_pkg::t_cfg      i_cfg,
    input  cvmcc_pkg::t_scan_req i_req,
    output logic                 o_idle,
    cvmcc_out_if.source          o_out
);
    import cvmcc_pkg::*;

    t_scan_state r_state, n_state;

    // sample memory, valid bits make unwritten entries read 0 mV
    logic signed [MV_W-1:0] r_smp_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_smp_valid;
    logic signed [MV_W-1:0] r_smp_rd;
    logic                   r_smp_ok;
    logic signed [MV_W-1:0] smp_mv;

    // last-sent table, an invalid entry means none sent
    logic [VAL_W-1:0]           r_tab_mem [NUM_CONTROLLERS];
    logic [NUM_CONTROLLERS-1:0] r_tab_valid;
    logic [VAL_W-1:0]           r_tab_rd;
    logic                       r_tab_ok;

    logic [CH_W-1:0]  r_ch;
    logic [CC_W-1:0]  cc_now;
    logic [CC_W-1:0]  r_cc;
    logic [VAL_W-1:0] q_value;

    logic             r_pend_valid;
    logic [CC_W-1:0]  r_pend_cc;
    logic [VAL_W-1:0] r_pend_val;

    logic              r_out_valid;
    logic [MIDI_W-1:0] r_out_chan;
    logic [CC_W-1:0]   r_out_cc;
    logic [VAL_W-1:0]  r_out_val;
    logic              r_out_last;

    logic found, out_free, stall, last_ch;
    logic tab_we, pend_load, pend_clear, out_load, out_last, ch_inc, ch_clr;

    assign cc_now   = cc_of(i_cfg, CHF_W'(r_ch));
    assign smp_mv   = r_smp_ok ? r_smp_rd : '0;
    assign found    = !(r_tab_ok && (r_tab_rd == q_value));
    assign out_free = !r_out_valid || o_out.ready;
    assign stall    = found && r_pend_valid && !out_free;
    assign last_ch  = (r_ch == CH_W'(NUM_CHANNELS - 1));
    assign o_idle   = (r_state == ST_IDLE);

    cvmcc_quantizer u_quant (
        .i_clk   (i_clk),
        .i_mv    (smp_mv),
        .o_value (q_value)
    );

    // sample memory port
    always_ff @(posedge i_clk) begin
        if (i_req.smp_we) begin
            r_smp_mem[i_req.smp_ch] <= i_req.smp_mv;
        end
        r_smp_rd <= r_smp_mem[r_ch];
        r_smp_ok <= r_smp_valid[r_ch];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_valid <= '0;
        end else if (i_req.smp_we) begin
            r_smp_valid[i_req.smp_ch] <= 1'b1;
        end
    end

    // last-sent table port
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab_mem[r_cc] <= q_value;
        end
        r_tab_rd <= r_tab_mem[cc_now];
        r_tab_ok <= r_tab_valid[cc_now];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_valid <= '0;
        end else if (tab_we) begin
            r_tab_valid[r_cc] <= 1'b1;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and control
    always_comb begin
        n_state    = r_state;
        tab_we     = 1'b0;
        pend_load  = 1'b0;
        pend_clear = 1'b0;
        out_load   = 1'b0;
        out_last   = 1'b0;
        ch_inc     = 1'b0;
        ch_clr     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_req.start) begin
                    ch_clr  = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_MULT;
            ST_MULT: n_state = ST_CMP;
            ST_CMP: begin
                if (!stall) begin
                    if (found) begin
                        tab_we    = 1'b1;
                        pend_load = 1'b1;
                        out_load  = r_pend_valid;
                    end
                    if (last_ch) begin
                        n_state = ST_FLUSH;
                    end else begin
                        ch_inc  = 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    pend_clear = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // channel counter and captured controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= '0;
        end else if (ch_clr) begin
            r_ch <= '0;
        end else if (ch_inc) begin
            r_ch <= r_ch + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MULT) begin
            r_cc <= cc_now;
        end
    end

    // pending word, held until it is known whether another follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (pend_load) begin
            r_pend_valid <= 1'b1;
        end else if (pend_clear) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_load) begin
            r_pend_cc  <= r_cc;
            r_pend_val <= q_value;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_chan <= i_cfg.midi_channel;
            r_out_cc   <= r_pend_cc;
            r_out_val  <= r_pend_val;
            r_out_last <= out_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.midi_chan  = r_out_chan;
    assign o_out.controller = r_out_cc;
    assign o_out.cc_value   = r_out_val;
    assign o_out.last       = r_out_last;

`ifndef ASSERT_OFF
    // no word is left pending once a scan has finished
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("pending word left after scan");

    // a scan starts only from idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == ST_IDLE))
        else $error("scan start while busy");

    // a stalled compare keeps its channel
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP && stall) |=> (r_state == ST_CMP && $stable(r_ch)))
        else $error("compare stall lost its channel");

    // words become pending only from the compare step
    a_pend_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pend_valid) |-> ($past(r_state) == ST_CMP))
        else $error("pending word from wrong step");
`endif

endmodule

[rtl/cv_to_midi_cc_scanner_unit.sv]
// top level: item front end, phase accumulator, config and scan engine
// sample and tick words are taken in one cycle each while no scan runs
// a carry starts a scan that takes each channel through read, multiply and compare
// states, then a flush state, paced by the read-modify-write of the last-sent table
// a full output register stalls the scan at the next changed channel
// reset (synchronous, active low) restores registers, zeroes phase, marks all
// samples 0 mV and all controllers none-sent through valid bits
module cv_to_midi_cc_scanner_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cvmcc_in_if.sink    i_in,
    cvmcc_out_if.source o_out,
    cvmcc_cfg_if.sink   i_cfg
);
    import cvmcc_pkg::*;

    t_cfg      cfg;
    t_scan_req req;
    logic      eng_idle;
    logic      accept;

    logic [PHASE_BITS-1:0] r_phase_acc;
    logic [PHASE_BITS:0]   phase_sum;

    cvmcc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // words are taken whenever no scan is running
    assign i_in.ready = eng_idle;
    assign accept     = i_in.valid && eng_idle;

    // phase accumulator, carry out starts a scan
    assign phase_sum = {1'b0, r_phase_acc} + {1'b0, PHASE_BITS'(cfg.phase_step)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
        end else if (accept && (i_in.kind == KIND_TICK)) begin
            r_phase_acc <= phase_sum[PHASE_BITS-1:0];
        end
    end

    // requests to the engine
    assign req.start  = accept && (i_in.kind == KIND_TICK) && phase_sum[PHASE_BITS];
    assign req.smp_we = accept && (i_in.kind == KIND_SAMPLE)
                        && ({1'b0, i_in.channel} < (CHF_W + 1)'(NUM_CHANNELS));
    assign req.smp_ch = CH_W'(i_in.channel);
    assign req.smp_mv = i_in.voltage_mv;

    cvmcc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (req),
        .o_idle  (eng_idle),
        .o_out   (o_out)
    );

endmodule
